@@ rtl/pre_pkg.sv @@
// ----------------------------------------------------------------------------
// Page replacement engine package
// Shared sizes, policy codes, register indexes and the page-state entry type.
// ----------------------------------------------------------------------------
package pre_pkg;

   // Sizes of the stores.
   localparam int MAX_PROCS      = 8;
   localparam int PAGES_PER_PROC = 256;
   localparam int MAX_FRAMES     = 16;

   localparam int PROC_W  = 3;
   localparam int PAGE_W  = 8;
   localparam int POS_W   = 4;
   localparam int USED_W  = 5;
   localparam int LOC_W   = 18;
   localparam int PSIZE_W = 10;
   localparam int FLIM_W  = 5;
   localparam int SWAP_W  = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   localparam int RB_DEPTH = MAX_PROCS * PAGES_PER_PROC;
   localparam int RB_AW    = PROC_W + PAGE_W;
   localparam int FO_DEPTH = MAX_PROCS * MAX_FRAMES;
   localparam int FO_AW    = PROC_W + POS_W;

   // Replacement policy codes.
   localparam logic [1:0] POL_FIFO  = 2'd0;
   localparam logic [1:0] POL_LRU   = 2'd1;
   localparam logic [1:0] POL_CLOCK = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_POLICY  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PREPAGE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PSIZE   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES  = 2'd3;

   // One entry of the page-state memory.
   typedef struct packed {
      logic res;
      logic refb;
   } page_state_type;

endpackage

@@ rtl/page_replacement_engine_unit.sv @@
// ----------------------------------------------------------------------------
// Page replacement engine
// Per-process resident sets under FIFO, LRU or clock, with optional prepaging
// and a running swap count. Page state and frame lists live in two RAMs.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  req_      in         req_tvalid/req_tready  proc_id, location, last_page
//  rsp_      out        rsp_tvalid/rsp_tready  hit .. range_error, one per request
//  csr_      in         csr_we                 policy, prepage_on, page_size, frames
//
//  After reset a clearing pass zeroes all 2048 entries of the page-state RAM;
//  no request is taken until it ends.
//  A request taken first waits on the page divide. The prepage scan, LRU search
//  and list shift walk the entries one at a time through a read state and a
//  check or write state, and the clock sweep through read, reference read and
//  check states. A full result register holds the sequencer until it drains.
//  One request is worked at a time; a new one is taken while a result waits.
// ----------------------------------------------------------------------------
module page_replacement_engine_unit
   import pre_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // proc_id[2:0], location[20:3], last_page[28:21]
   input  logic [31:0]           req_tdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // hit[0], page_index[8:1], prefetch_valid[9], prefetch_page[17:10],
   // swaps_now[19:18], swap_total[51:20], range_error[52]
   output logic [55:0]           rsp_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_DIV, ST_LOOK, ST_PF_RD, ST_PF_CHK,
      ST_LRU_RD, ST_LRU_CHK, ST_SH_RD, ST_SH_WR, ST_PLACE, ST_EV_FIFO,
      ST_CK_RD, ST_CK_RB, ST_CK_CHK, ST_CK_WR, ST_MARK, ST_DONE
   } state_type;

   // Configuration registers.
   logic [1:0]         policy_ff;
   logic               prepage_ff;
   logic [PSIZE_W-1:0] psize_ff;
   logic [FLIM_W-1:0]  frames_ff;

   // Control and request registers.
   state_type          state_ff;
   logic [RB_AW-1:0]   clr_cnt_ff;
   logic [PROC_W-1:0]  proc_ff;
   logic [PAGE_W-1:0]  page_ff;
   logic [PAGE_W-1:0]  last_ff;
   logic               hit_ff;
   logic               range_ff;
   logic               pf_valid_ff;
   logic [PAGE_W-1:0]  pf_page_ff;
   logic [PAGE_W-1:0]  scan_ff;
   logic [1:0]         swaps_ff;
   logic [SWAP_W-1:0]  swap_total_ff;
   logic               second_ff;
   logic               sh_place_ff;
   logic [POS_W-1:0]   idx_ff;
   logic [PAGE_W-1:0]  vpg_ff;
   logic [USED_W-1:0]  used_ff [MAX_PROCS];
   logic [POS_W-1:0]   hand_ff [MAX_PROCS];

   // Result register.
   logic               rsp_valid_ff;
   logic [55:0]        rsp_data_ff;

   // Memories.
   page_state_type     rb_mem [RB_DEPTH];
   logic [PAGE_W-1:0]  fo_mem [FO_DEPTH];
   page_state_type     rb_q_ff;
   logic [PAGE_W-1:0]  fo_q_ff;

   logic               rb_we, rb_re, fo_we, fo_re;
   logic [RB_AW-1:0]   rb_addr;
   page_state_type     rb_wdata;
   logic [FO_AW-1:0]   fo_addr;
   logic [PAGE_W-1:0]  fo_wdata;

   // Divider hookup.
   logic               req_fire;
   logic               div_done;
   logic [LOC_W-1:0]   div_quo;
   logic [LOC_W-1:0]   div_num;
   logic [PSIZE_W-1:0] div_den;

   logic [USED_W-1:0]  used_cur;
   logic [POS_W-1:0]   hand_cur;
   logic [USED_W-1:0]  limit;
   logic [PAGE_W-1:0]  tgt_page;
   logic [USED_W-1:0]  idx_p1;
   logic [POS_W-1:0]   idx_nxt;
   logic [SWAP_W:0]    total_sum;
   logic [SWAP_W-1:0]  swap_next;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign div_num    = (req_tdata[20:3] != '0) ? (req_tdata[20:3] - LOC_W'(1)) : '0;
   assign div_den    = (psize_ff != '0) ? psize_ff : PSIZE_W'(1);

   pre_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (req_fire),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Per-process view and derived values.
   assign used_cur = used_ff[proc_ff];
   assign hand_cur = (USED_W'(hand_ff[proc_ff]) >= used_cur) ? '0 : hand_ff[proc_ff];
   assign limit    = (frames_ff == '0) ? USED_W'(1) :
                     (frames_ff > USED_W'(MAX_FRAMES)) ? USED_W'(MAX_FRAMES) : frames_ff;
   assign tgt_page = second_ff ? pf_page_ff : page_ff;
   assign idx_p1   = USED_W'(idx_ff) + USED_W'(1);
   assign idx_nxt  = (idx_p1 < used_cur) ? idx_p1[POS_W-1:0] : '0;
   assign total_sum = {1'b0, swap_total_ff} + (SWAP_W + 1)'(swaps_ff);
   assign swap_next = total_sum[SWAP_W] ? {SWAP_W{1'b1}} : total_sum[SWAP_W-1:0];

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff  <= POL_FIFO;
         prepage_ff <= 1'b0;
         psize_ff   <= PSIZE_W'(64);
         frames_ff  <= FLIM_W'(16);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_POLICY:  policy_ff  <= csr_wdata[1:0];
            CSR_PREPAGE: prepage_ff <= csr_wdata[0];
            CSR_PSIZE:   psize_ff   <= csr_wdata[PSIZE_W-1:0];
            CSR_FRAMES:  frames_ff  <= csr_wdata[FLIM_W-1:0];
            default: ;
         endcase
      end
   end

   // RAM port control decoded from the current state.
   always_comb begin
      rb_we    = 1'b0;
      rb_re    = 1'b0;
      rb_addr  = {proc_ff, page_ff};
      rb_wdata = '{res: 1'b0, refb: 1'b0};
      fo_we    = 1'b0;
      fo_re    = 1'b0;
      fo_addr  = {proc_ff, idx_ff};
      fo_wdata = tgt_page;
      case (state_ff)
         ST_CLEAR: begin
            rb_we   = 1'b1;
            rb_addr = clr_cnt_ff;
         end
         ST_DIV: begin
            rb_re   = div_done;
            rb_addr = {proc_ff, div_quo[PAGE_W-1:0]};
         end
         ST_LOOK: begin
            rb_we    = rb_q_ff.res;
            rb_wdata = '{res: 1'b1, refb: 1'b1};
         end
         ST_PF_RD: begin
            rb_re   = 1'b1;
            rb_addr = {proc_ff, scan_ff};
         end
         ST_LRU_RD: fo_re = 1'b1;
         ST_SH_RD: begin
            if (idx_p1 < used_cur) begin
               fo_re   = 1'b1;
               fo_addr = {proc_ff, idx_p1[POS_W-1:0]};
            end else begin
               fo_we = 1'b1;
            end
         end
         ST_SH_WR: begin
            fo_we    = 1'b1;
            fo_wdata = fo_q_ff;
         end
         ST_PLACE: begin
            if (used_cur < limit) begin
               fo_we   = 1'b1;
               fo_addr = {proc_ff, used_cur[POS_W-1:0]};
            end else if (policy_ff != POL_CLOCK) begin
               fo_re   = 1'b1;
               fo_addr = {proc_ff, POS_W'(0)};
            end
         end
         ST_EV_FIFO: begin
            rb_we   = 1'b1;
            rb_addr = {proc_ff, fo_q_ff};
         end
         ST_CK_RD: fo_re = 1'b1;
         ST_CK_RB: begin
            rb_re   = 1'b1;
            rb_addr = {proc_ff, fo_q_ff};
         end
         ST_CK_CHK: begin
            rb_we    = 1'b1;
            rb_addr  = {proc_ff, vpg_ff};
            rb_wdata = '{res: rb_q_ff.refb, refb: 1'b0};
         end
         ST_CK_WR: fo_we = 1'b1;
         ST_MARK: begin
            rb_we    = 1'b1;
            rb_addr  = {proc_ff, tgt_page};
            rb_wdata = '{res: 1'b1, refb: 1'b0};
         end
         default: ;
      endcase
   end

   // Page-state RAM.
   always_ff @(posedge clock) begin
      if (rb_we) rb_mem[rb_addr] <= rb_wdata;
      if (rb_re) rb_q_ff <= rb_mem[rb_addr];
   end

   // Frame-list RAM.
   always_ff @(posedge clock) begin
      if (fo_we) fo_mem[fo_addr] <= fo_wdata;
      if (fo_re) fo_q_ff <= fo_mem[fo_addr];
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         proc_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         swap_total_ff <= '0;
         for (int i = 0; i < MAX_PROCS; i++) begin
            used_ff[i] <= '0;
            hand_ff[i] <= '0;
         end
      end else begin
         // The result register loads when the slot is free or drains this cycle.
         if ((state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready)) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + RB_AW'(1);
               if (clr_cnt_ff == '1) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (req_fire) begin
                  proc_ff     <= req_tdata[2:0];
                  last_ff     <= req_tdata[28:21];
                  hit_ff      <= 1'b0;
                  pf_valid_ff <= 1'b0;
                  pf_page_ff  <= '0;
                  swaps_ff    <= '0;
                  second_ff   <= 1'b0;
                  state_ff    <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  page_ff  <= div_quo[PAGE_W-1:0];
                  range_ff <= (div_quo[LOC_W-1:PAGE_W] != '0);
                  if (div_quo[LOC_W-1:PAGE_W] != '0) begin
                     // Page beyond the table: report and leave state alone.
                     state_ff <= ST_DONE;
                  end else begin
                     state_ff <= ST_LOOK;
                  end
               end
            end
            ST_LOOK: begin
               if (rb_q_ff.res) begin
                  hit_ff <= 1'b1;
                  idx_ff <= '0;
                  state_ff <= (policy_ff == POL_LRU) ? ST_LRU_RD : ST_DONE;
               end else if (prepage_ff && (last_ff > page_ff)) begin
                  scan_ff  <= page_ff + PAGE_W'(1);
                  state_ff <= ST_PF_RD;
               end else begin
                  state_ff <= ST_PLACE;
               end
            end
            ST_PF_RD: state_ff <= ST_PF_CHK;
            ST_PF_CHK: begin
               if (!rb_q_ff.res) begin
                  pf_valid_ff <= 1'b1;
                  pf_page_ff  <= scan_ff;
                  state_ff    <= ST_PLACE;
               end else if (scan_ff == last_ff) begin
                  state_ff <= ST_PLACE;
               end else begin
                  scan_ff  <= scan_ff + PAGE_W'(1);
                  state_ff <= ST_PF_RD;
               end
            end
            // Search the list for the hit page, then move it to the newest end.
            ST_LRU_RD: state_ff <= ST_LRU_CHK;
            ST_LRU_CHK: begin
               if (fo_q_ff == page_ff) begin
                  sh_place_ff <= 1'b0;
                  state_ff    <= ST_SH_RD;
               end else if (idx_p1 < used_cur) begin
                  idx_ff   <= idx_p1[POS_W-1:0];
                  state_ff <= ST_LRU_RD;
               end else begin
                  state_ff <= ST_DONE;
               end
            end
            // Shift entries above idx down by one; the tail takes the target page (new or hit).
            ST_SH_RD: begin
               if (idx_p1 < used_cur) state_ff <= ST_SH_WR;
               else state_ff <= sh_place_ff ? ST_MARK : ST_DONE;
            end
            ST_SH_WR: begin
               idx_ff   <= idx_p1[POS_W-1:0];
               state_ff <= ST_SH_RD;
            end
            ST_PLACE: begin
               if (used_cur < limit) begin
                  used_ff[proc_ff] <= used_cur + USED_W'(1);
                  state_ff <= ST_MARK;
               end else if (policy_ff == POL_CLOCK) begin
                  idx_ff   <= hand_cur;
                  state_ff <= ST_CK_RD;
               end else begin
                  state_ff <= ST_EV_FIFO;
               end
            end
            ST_EV_FIFO: begin
               swaps_ff    <= swaps_ff + 2'd1;
               idx_ff      <= '0;
               sh_place_ff <= 1'b1;
               state_ff    <= ST_SH_RD;
            end
            // Clock sweep: clear set reference bits until a clear one is found.
            ST_CK_RD: state_ff <= ST_CK_RB;
            ST_CK_RB: begin
               vpg_ff   <= fo_q_ff;
               state_ff <= ST_CK_CHK;
            end
            ST_CK_CHK: begin
               if (!rb_q_ff.refb) begin
                  hand_ff[proc_ff] <= idx_nxt;
                  swaps_ff <= swaps_ff + 2'd1;
                  state_ff <= ST_CK_WR;
               end else begin
                  idx_ff   <= idx_nxt;
                  state_ff <= ST_CK_RD;
               end
            end
            ST_CK_WR: state_ff <= ST_MARK;
            ST_MARK: begin
               if (hit_ff) begin
                  state_ff <= ST_DONE;
               end else if (!second_ff && pf_valid_ff) begin
                  second_ff <= 1'b1;
                  state_ff  <= ST_PLACE;
               end else begin
                  state_ff <= ST_DONE;
               end
            end
            // Hand the result over once the result register is free.
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  swap_total_ff <= swap_next;
                  rsp_data_ff   <= {3'b000, range_ff, swap_next, swaps_ff, pf_page_ff,
                                    pf_valid_ff, page_ff, hit_ff};
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A process never holds more frames than the list can carry.
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff[proc_ff] <= USED_W'(MAX_FRAMES))
      else $error("frame count above list size");

   // A hit never evicts anything.
   a_hit_no_swap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && hit_ff) |-> (swaps_ff == '0))
      else $error("eviction on a hit");

   // A rejected request reports no hit and no eviction.
   a_range_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[52]) |-> (rsp_data_ff[0] == 1'b0 &&
                                              rsp_data_ff[19:18] == 2'b00))
      else $error("range error with side effects");

   // The divider only finishes while the sequencer waits for it.
   a_div_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divide finished outside its wait state");

endmodule

@@ rtl/pre_div.sv @@
// ----------------------------------------------------------------------------
// Page index divider
// Restoring divider, one quotient bit per cycle, for location / page size.
// ----------------------------------------------------------------------------
module pre_div
   import pre_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [LOC_W-1:0]   dividend,
   input  logic [PSIZE_W-1:0] divisor,
   output logic               done,
   output logic [LOC_W-1:0]   quotient
);

   logic               busy_ff;
   logic               done_ff;
   logic [4:0]         cnt_ff;
   logic [LOC_W-1:0]   quo_ff;
   logic [PSIZE_W-1:0] rem_ff;
   logic [PSIZE_W-1:0] dvs_ff;
   logic [PSIZE_W:0]   trial;
   logic               fits;

   // Shift the next dividend bit into the remainder and try a subtract.
   assign trial = {rem_ff, quo_ff[LOC_W-1]};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'(LOC_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[LOC_W-2:0], fits};
         rem_ff <= fits ? PSIZE_W'(trial - {1'b0, dvs_ff}) : trial[PSIZE_W-1:0];
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
